// File: design/ecc_pkg.sv
package ecc_pkg;

   localparam logic OP_SPLIT = 1'b0;
   localparam logic OP_PACK  = 1'b1;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_TIME = 2'd1;
   localparam logic [1:0] ST_BAD_DATE = 2'd2;
   localparam logic [1:0] ST_OVERFLOW = 2'd3;

   localparam logic [11:0] BASE_YEAR    = 12'd1970;
   localparam logic [2:0]  BASE_WEEKDAY = 3'd4;

   typedef struct packed {
      logic        operation;
      logic [31:0] epoch;
      logic [11:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [1:0]  status;
   } job_type;

   function automatic logic is_leap(input logic [11:0] y);
      logic [11:0] q100;
      logic [11:0] r100;
      q100 = 12'((24'(y) * 24'd2622) >> 18);
      r100 = 12'(y - 12'(q100 * 12'd100));
      if (r100 == 12'd0) begin
         return q100[1:0] == 2'd0;
      end
      return y[1:0] == 2'd0;
   endfunction

   function automatic logic [8:0] year_len(input logic [11:0] y);
      return is_leap(y) ? 9'd366 : 9'd365;
   endfunction

   function automatic logic [4:0] month_len(input logic [3:0] m0, input logic [11:0] y);
      logic [4:0] d;
      unique case (m0)
         4'd1: d = is_leap(y) ? 5'd29 : 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
         default: d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

// File: design/ecc_front.sv
module ecc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_operation,
   input  logic [31:0]          req_epoch_in,
   input  logic [11:0]          req_year_in,
   input  logic [3:0]           req_month_in,
   input  logic [4:0]           req_day_in,
   input  logic [4:0]           req_hour_in,
   input  logic [5:0]           req_minute_in,
   input  logic [5:0]           req_second_in,
   output logic                 job_valid,
   input  logic                 job_ready,
   output ecc_pkg::job_type     job
);

   logic [1:0] status;
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   ecc_pkg::job_type queue_ff [2];
   ecc_pkg::job_type entry;
   logic push, pop;

   always_comb begin
      status = ecc_pkg::ST_OK;
      if (req_operation == ecc_pkg::OP_PACK) begin
         if (req_hour_in > 5'd23 || req_minute_in > 6'd59 || req_second_in > 6'd59) begin
            status = ecc_pkg::ST_BAD_TIME;
         end else if (req_year_in < ecc_pkg::BASE_YEAR || req_month_in == 4'd0
                      || req_month_in > 4'd12 || req_day_in == 5'd0
                      || req_day_in > ecc_pkg::month_len(4'(req_month_in - 4'd1), req_year_in))
         begin
            status = ecc_pkg::ST_BAD_DATE;
         end
      end
      entry = '{req_operation, req_epoch_in, req_year_in, req_month_in, req_day_in,
                req_hour_in, req_minute_in, req_second_in, status};
   end

   assign req_ready = count_ff != 2'd2;
   assign job_valid = count_ff != 2'd0;
   assign job       = queue_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = job_valid && job_ready;

   always_comb begin
      count_in  = 2'(count_ff + {1'b0, push} - {1'b0, pop});
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= 2'd0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= entry;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset) count_ff <= 2'd2)
      else $error("queue count out of range");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      count_ff == 2'd2 |-> !push) else $error("push into full queue");
   a_ptr_diff: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) == (wr_ptr_ff != rd_ptr_ff)) else $error("pointer mismatch");

endmodule

// File: design/ecc_back.sv
module ecc_back #(
   parameter int EPOCH_WIDTH = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  ecc_pkg::job_type     job,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_epoch_out,
   output logic [11:0]          rsp_year_out,
   output logic [3:0]           rsp_month_out,
   output logic [4:0]           rsp_day_out,
   output logic [4:0]           rsp_hour_out,
   output logic [5:0]           rsp_minute_out,
   output logic [5:0]           rsp_second_out,
   output logic [2:0]           rsp_weekday_out,
   output logic [1:0]           rsp_status
);

   localparam int SW = EPOCH_WIDTH + 8;

   typedef enum logic [6:0] {
      S_IDLE  = 7'b0000001,
      S_SPLIT = 7'b0000010,
      S_YEAR  = 7'b0000100,
      S_MONTH = 7'b0001000,
      S_WDAY  = 7'b0010000,
      S_PACK  = 7'b0100000,
      S_OUT   = 7'b1000000
   } state_type;

   state_type   state_ff, state_in;
   ecc_pkg::job_type job_ff, job_in;
   logic [31:0] rem_ff, rem_in;
   logic [19:0] days_ff, days_in;
   logic [16:0] wk_ff, wk_in;
   logic [11:0] year_ff, year_in;
   logic [3:0]  mon_ff, mon_in;
   logic [1:0]  phase_ff, phase_in;
   logic [SW-1:0] secs_ff, secs_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] o_epoch_ff, o_epoch_in;
   logic [11:0] o_year_ff, o_year_in;
   logic [3:0]  o_month_ff, o_month_in;
   logic [4:0]  o_day_ff, o_day_in;
   logic [4:0]  o_hour_ff, o_hour_in;
   logic [5:0]  o_min_ff, o_min_in;
   logic [5:0]  o_sec_ff, o_sec_in;
   logic [2:0]  o_wday_ff, o_wday_in;
   logic [1:0]  o_stat_ff, o_stat_in;
   logic [8:0]  ylen;
   logic [4:0]  mlen;
   logic [31:0] q60;
   logic [5:0]  r60;
   logic [31:0] q24;
   logic [4:0]  r24;
   logic [20:0] q7;
   logic [2:0]  r7;

   assign ylen = ecc_pkg::year_len(year_ff);
   assign mlen = ecc_pkg::month_len(mon_ff, year_ff);
   assign q60  = 32'((64'(rem_ff) * 64'h8888_8889) >> 37);
   assign r60  = 6'(rem_ff - 32'(q60 * 32'd60));
   assign q24  = 32'((64'(rem_ff) * 64'hAAAA_AAAB) >> 36);
   assign r24  = 5'(rem_ff - 32'(q24 * 32'd24));
   assign q7   = 21'((43'(rem_ff[20:0]) * 43'd2396746) >> 24);
   assign r7   = 3'(rem_ff[20:0] - 21'(q7 * 21'd7));

   assign job_ready = state_ff == S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_epoch_out   = o_epoch_ff;
   assign rsp_year_out    = o_year_ff;
   assign rsp_month_out   = o_month_ff;
   assign rsp_day_out     = o_day_ff;
   assign rsp_hour_out    = o_hour_ff;
   assign rsp_minute_out  = o_min_ff;
   assign rsp_second_out  = o_sec_ff;
   assign rsp_weekday_out = o_wday_ff;
   assign rsp_status      = o_stat_ff;

   always_comb begin
      state_in = state_ff; job_in = job_ff; rem_in = rem_ff; days_in = days_ff;
      wk_in = wk_ff; year_in = year_ff; mon_in = mon_ff; phase_in = phase_ff;
      secs_in = secs_ff; rsp_valid_in = rsp_valid_ff;
      o_epoch_in = o_epoch_ff; o_year_in = o_year_ff; o_month_in = o_month_ff;
      o_day_in = o_day_ff; o_hour_in = o_hour_ff; o_min_in = o_min_ff;
      o_sec_in = o_sec_ff; o_wday_in = o_wday_ff; o_stat_in = o_stat_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (job_valid) begin
               job_in = job; rem_in = job.epoch; phase_in = 2'd0;
               year_in = ecc_pkg::BASE_YEAR; mon_in = 4'd0;
               days_in = 20'(job.day - 5'd1);
               if (job.operation == ecc_pkg::OP_SPLIT) begin
                  state_in = S_SPLIT;
               end else if (job.status != ecc_pkg::ST_OK) begin
                  state_in = S_OUT;
               end else begin
                  state_in = S_YEAR;
               end
            end
         end
         S_SPLIT: begin
            phase_in = 2'(phase_ff + 2'd1);
            unique case (phase_ff)
               2'd0: begin job_in.second = r60; rem_in = q60; end
               2'd1: begin job_in.minute = r60; rem_in = q60; end
               default: begin
                  job_in.hour = r24; days_in = 20'(q24);
                  wk_in = 17'(q24); state_in = S_YEAR;
               end
            endcase
         end
         S_YEAR: begin
            if (job_ff.operation == ecc_pkg::OP_SPLIT) begin
               if (days_ff >= 20'(ylen)) begin
                  days_in = 20'(days_ff - 20'(ylen)); year_in = 12'(year_ff + 12'd1);
               end else begin
                  state_in = S_MONTH;
               end
            end else if (year_ff < job_ff.year) begin
               days_in = 20'(days_ff + 20'(ylen)); year_in = 12'(year_ff + 12'd1);
            end else begin
               state_in = S_MONTH;
            end
         end
         S_MONTH: begin
            if (job_ff.operation == ecc_pkg::OP_SPLIT) begin
               if (mon_ff < 4'd11 && days_ff >= 20'(mlen)) begin
                  days_in = 20'(days_ff - 20'(mlen)); mon_in = 4'(mon_ff + 4'd1);
               end else begin
                  job_in.year = year_ff; job_in.month = 4'(mon_ff + 4'd1);
                  job_in.day = 5'(days_ff + 20'd1);
                  rem_in = 32'(wk_ff) + 32'(ecc_pkg::BASE_WEEKDAY);
                  state_in = S_WDAY;
               end
            end else if (4'(mon_ff + 4'd1) < job_ff.month) begin
               days_in = 20'(days_ff + 20'(mlen)); mon_in = 4'(mon_ff + 4'd1);
            end else begin
               rem_in = 32'(days_ff) + 32'(ecc_pkg::BASE_WEEKDAY);
               secs_in = SW'(days_ff); phase_in = 2'd0;
               state_in = S_PACK;
            end
         end
         S_PACK: begin
            phase_in = 2'(phase_ff + 2'd1);
            unique case (phase_ff)
               2'd0: secs_in = SW'(secs_ff * SW'(24)) + SW'(job_ff.hour);
               2'd1: secs_in = SW'(secs_ff * SW'(60)) + SW'(job_ff.minute);
               2'd2: secs_in = SW'(secs_ff * SW'(60)) + SW'(job_ff.second);
               default: begin
                  if (secs_ff[SW-1:EPOCH_WIDTH] != '0) begin
                     job_in.status = ecc_pkg::ST_OVERFLOW; job_in.epoch = '0;
                  end else begin
                     job_in.epoch = secs_ff[31:0];
                  end
                  state_in = S_WDAY;
               end
            endcase
         end
         S_WDAY: begin
            rem_in = 32'(r7);
            state_in = S_OUT;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
               if (job_ff.status == ecc_pkg::ST_BAD_TIME
                   || job_ff.status == ecc_pkg::ST_BAD_DATE) begin
                  o_epoch_in = '0; o_year_in = '0; o_month_in = '0; o_day_in = '0;
                  o_hour_in = '0; o_min_in = '0; o_sec_in = '0; o_wday_in = '0;
               end else begin
                  o_epoch_in = job_ff.epoch; o_year_in = job_ff.year;
                  o_month_in = job_ff.month; o_day_in = job_ff.day;
                  o_hour_in = job_ff.hour; o_min_in = job_ff.minute;
                  o_sec_in = job_ff.second; o_wday_in = 3'(rem_ff);
               end
               o_stat_in = job_ff.status;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in; rem_ff <= rem_in; days_ff <= days_in; wk_ff <= wk_in;
      year_ff <= year_in; mon_ff <= mon_in; phase_ff <= phase_in; secs_ff <= secs_in;
      o_epoch_ff <= o_epoch_in; o_year_ff <= o_year_in; o_month_ff <= o_month_in;
      o_day_ff <= o_day_in; o_hour_ff <= o_hour_in; o_min_ff <= o_min_in;
      o_sec_ff <= o_sec_in; o_wday_ff <= o_wday_in; o_stat_ff <= o_stat_in;
   end

   a_onehot: assert property (@(posedge clock) disable iff (reset) $onehot(state_ff))
      else $error("state not one-hot");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |=> rsp_valid_ff && $stable(o_epoch_ff))
      else $error("result dropped");
   a_wday: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> o_wday_ff <= 3'd6) else $error("weekday out of range");

endmodule

// File: design/epoch_calendar_converter_core.sv
// A pack with a bad time or date skips the conversion and goes straight to the result.
// A split and a pack each step one year at a time from 1970, then one month at a time.
// The single iterative back end handles one word at a time: it takes the next word
// only once it is idle again, after a result is registered.
// A two-entry queue lets a word be taken while the back end is busy.
// Synchronous active-high reset empties the queue and clears the result valid.
module epoch_calendar_converter_core #(
   parameter int EPOCH_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_operation,
   input  logic [31:0] req_epoch_in,
   input  logic [11:0] req_year_in,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_epoch_out,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [2:0]  rsp_weekday_out,
   output logic [1:0]  rsp_status
);

   logic job_valid, job_ready;
   ecc_pkg::job_type job;

   ecc_front u_front (
      .clock, .reset, .req_valid, .req_ready, .req_operation, .req_epoch_in,
      .req_year_in, .req_month_in, .req_day_in, .req_hour_in, .req_minute_in,
      .req_second_in, .job_valid, .job_ready, .job
   );

   ecc_back #(.EPOCH_WIDTH(EPOCH_WIDTH)) u_back (
      .clock, .reset, .job_valid, .job_ready, .job, .rsp_valid, .rsp_ready,
      .rsp_epoch_out, .rsp_year_out, .rsp_month_out, .rsp_day_out, .rsp_hour_out,
      .rsp_minute_out, .rsp_second_out, .rsp_weekday_out, .rsp_status
   );

endmodule
